### design/slkc_pkg.sv
// ----------------------------------------------------------------------------
// slkc_pkg: shared types and constants
// Widths and codes for the single-linkage clustering block.
// ----------------------------------------------------------------------------
`default_nettype none
package slkc_pkg;
    localparam int MAX_POINTS = 256;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int K_BITS     = 9;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int FIX_BITS   = COORD_BITS + 1 + FRAC_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQRT_STEPS = (SQ_BITS + 1) / 2 + FRAC_BITS;
    localparam int SSTEP_BITS = $clog2(SQRT_STEPS + 1);
    localparam int REM_BITS   = FIX_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [SQ_BITS-1:0]           t_sq;
    typedef logic [FIX_BITS-1:0]          t_fix;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_point;

    typedef struct packed {
        t_sq  sq;
        t_fix fix;
        logic few;
        logic dropped;
    } t_result;
endpackage
`default_nettype wire

### design/slkc_if.sv
// ----------------------------------------------------------------------------
// slkc_point_if / slkc_result_if: valid/ready channels
// Point input and result output channels of the clustering block.
// ----------------------------------------------------------------------------
`default_nettype none
interface slkc_point_if;
    logic            valid;
    logic            ready;
    slkc_pkg::t_point payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface slkc_result_if;
    logic             valid;
    logic             ready;
    slkc_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/slkc_sqrt.sv
// ----------------------------------------------------------------------------
// slkc_sqrt: digit-by-digit fixed-point square root
// One root bit per cycle; floor(sqrt(v) * 2^FRAC_BITS).
// ----------------------------------------------------------------------------
`default_nettype none
module slkc_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire slkc_pkg::t_sq i_value,
    output logic               o_done,
    output slkc_pkg::t_fix     o_root
);
    import slkc_pkg::*;

    localparam int RAD_BITS = 2 * SQRT_STEPS;

    logic [RAD_BITS-1:0]   r_rad;
    logic [REM_BITS-1:0]   r_rem;
    logic [FIX_BITS-1:0]   r_root;
    logic [SSTEP_BITS-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [REM_BITS-1:0] n_rem_sh;
    logic [REM_BITS-1:0] n_trial;

    always_comb begin
        n_rem_sh = {r_rem[REM_BITS-3:0], r_rad[RAD_BITS-1 -: 2]};
        n_trial  = {r_root[REM_BITS-3:0], 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SSTEP_BITS'(SQRT_STEPS);
                r_rad  <= RAD_BITS'({i_value, (2 * FRAC_BITS)'(0)});
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (n_rem_sh >= n_trial) begin
                    r_rem  <= n_rem_sh - n_trial;
                    r_root <= {r_root[FIX_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem_sh;
                    r_root <= {r_root[FIX_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SSTEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

### design/single_link_k_clustering.sv
// ----------------------------------------------------------------------------
// single_link_k_clustering: single-linkage k-clustering spacing
// Loads points, builds a minimum spanning tree and reports the spacing.
// ----------------------------------------------------------------------------
// Points load one per cycle into on-chip memory. The item flagged last
// starts the computation: Prim's tree build over n points runs through one
// shared distance unit, then the n-1 tree edges are ranked by counting to
// find the (n-k+1)-th smallest, and a bit-serial square root follows. The
// block is not ready from the last point until its result has been taken.
// Memories need no clearing.
`default_nettype none
module single_link_k_clustering (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [8:0]            i_cfg_data,
    slkc_point_if.sink                 i_point,
    slkc_result_if.source              o_result
);
    import slkc_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;   // link[v] = d(0,v)
    localparam logic [3:0] S_PICK  = 4'd2;   // scan for nearest outside node
    localparam logic [3:0] S_UPD   = 4'd3;   // relax from the picked node
    localparam logic [3:0] S_RANK  = 4'd4;   // count smaller edges per edge
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_WAIT  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;   // read latency bubble

    logic [K_BITS-1:0]   r_k;
    logic [3:0]          r_state;
    logic [3:0]          r_after;
    logic [CNT_BITS-1:0] r_n;
    logic                r_ovf;
    logic                r_few;
    logic                r_dropped;

    t_coord              xs [MAX_POINTS];
    t_coord              ys [MAX_POINTS];
    logic [SQ_BITS-1:0]  lk [MAX_POINTS];
    logic                r_in [MAX_POINTS];

    logic [CNT_BITS-1:0] r_v;
    logic [CNT_BITS-1:0] r_j;
    logic [IDX_BITS-1:0] r_pick;
    logic                r_found;
    t_sq                 r_best;
    t_coord              r_px, r_py;
    logic [CNT_BITS-1:0] r_round;
    logic [CNT_BITS-1:0] r_target;
    t_sq                 r_key;
    logic [CNT_BITS-1:0] r_less;
    logic [CNT_BITS-1:0] r_leq;
    t_sq                 r_ans;

    // registered memory reads
    t_coord              r_xr, r_yr;
    t_sq                 r_lr;
    logic                r_inr;

    logic [DIFF_BITS-1:0] n_dx, n_dy;
    logic signed [2*DIFF_BITS-1:0] n_sx, n_sy;
    logic [SQ_BITS-1:0]   n_d;
    logic [IDX_BITS-1:0]  n_addr;
    logic                 sq_start, sq_done;
    t_fix                 sq_root;
    logic                 acc;

    assign acc = i_point.valid && i_point.ready;
    assign i_point.ready = (r_state == S_LOAD);
    assign n_addr = r_v[IDX_BITS-1:0];
    assign n_dx = DIFF_BITS'(r_px) - DIFF_BITS'(r_xr);
    assign n_dy = DIFF_BITS'(r_py) - DIFF_BITS'(r_yr);
    // squares of 17-bit differences; each fits 32 bits
    assign n_sx = $signed(n_dx) * $signed(n_dx);
    assign n_sy = $signed(n_dy) * $signed(n_dy);
    assign n_d  = SQ_BITS'(n_sx) + SQ_BITS'(n_sy);

    always_ff @(posedge i_clk) begin
        if (acc && !r_n[IDX_BITS]) begin
            xs[r_n[IDX_BITS-1:0]] <= i_point.payload.x;
            ys[r_n[IDX_BITS-1:0]] <= i_point.payload.y;
        end
        r_xr <= xs[n_addr];
        r_yr <= ys[n_addr];
        r_lr <= lk[n_addr];
        r_inr <= r_in[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= K_BITS'(2);
            r_state <= S_LOAD;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            o_result.valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_k <= i_cfg_data;
            case (r_state)
                S_LOAD: begin
                    if (acc) begin
                        if (r_n[IDX_BITS]) r_ovf <= 1'b1;
                        else r_n <= r_n + 1'b1;
                        if (i_point.payload.last) begin
                            r_dropped <= r_ovf || r_n[IDX_BITS];
                            r_few <= (r_n[IDX_BITS] ? r_n : r_n + 1'b1) < CNT_BITS'(2);
                            r_ans <= '0;
                            if ((r_n[IDX_BITS] ? r_n : r_n + 1'b1) < CNT_BITS'(2)
                                || r_k <= K_BITS'(1)) begin
                                r_state <= S_SQRT;
                            end else begin
                                r_v <= '0;
                                r_after <= S_INIT;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    // first address is 0: load the reference point
                    r_state <= r_after;
                end
                S_INIT: begin
                    if (r_v == '0) begin
                        r_px <= r_xr; r_py <= r_yr;
                        r_in[0] <= 1'b1;
                        r_v <= r_v + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        lk[n_addr] <= n_d;
                        r_in[n_addr] <= 1'b0;
                        if (r_v == r_n - 1'b1) begin
                            r_round <= CNT_BITS'(1);
                            r_v <= CNT_BITS'(1);
                            r_found <= 1'b0;
                            r_after <= S_PICK;
                        end else begin
                            r_v <= r_v + 1'b1;
                        end
                        r_state <= S_RD;
                    end
                end
                S_PICK: begin
                    if (!r_inr && (!r_found || r_lr < r_best)) begin
                        r_best <= r_lr; r_pick <= n_addr; r_found <= 1'b1;
                    end
                    r_state <= S_RD;
                    if (r_v == r_n - 1'b1) begin
                        r_v <= '0;
                        r_after <= S_UPD;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_UPD: begin
                    // v==0 slot fetches the picked point's coordinates
                    if (r_v == '0) begin
                        r_in[r_pick] <= 1'b1;
                        r_v <= CNT_BITS'(r_pick);
                        r_state <= S_RD;
                        r_j <= CNT_BITS'(1);
                    end else if (r_j == CNT_BITS'(1) && n_addr == r_pick && r_found) begin
                        r_px <= r_xr; r_py <= r_yr;
                        r_found <= 1'b0;
                        r_v <= CNT_BITS'(1);
                        r_state <= S_RD;
                    end else begin
                        if (!r_inr && n_d < r_lr) lk[n_addr] <= n_d;
                        r_state <= S_RD;
                        if (r_v == r_n - 1'b1) begin
                            if (r_round == r_n - 1'b1) begin
                                r_target <= (CNT_BITS'(r_k) >= r_n + 1'b1
                                             || r_k >= K_BITS'(MAX_POINTS))
                                    ? CNT_BITS'(0) : r_n - CNT_BITS'(r_k);
                                r_v <= CNT_BITS'(1);
                                r_j <= CNT_BITS'(1);
                                r_less <= '0; r_leq <= '0;
                                r_after <= S_RANK;
                                r_found <= 1'b1;
                            end else begin
                                r_round <= r_round + 1'b1;
                                r_v <= CNT_BITS'(1);
                                r_after <= S_PICK;
                            end
                        end else begin
                            r_v <= r_v + 1'b1;
                        end
                    end
                end
                S_RANK: begin
                    // r_found: fetching the key edge r_j; else comparing edge r_v
                    if (r_found) begin
                        r_key <= r_lr;
                        r_found <= 1'b0;
                        r_v <= CNT_BITS'(1);
                        r_less <= '0; r_leq <= '0;
                        r_state <= S_RD;
                    end else begin
                        logic [CNT_BITS-1:0] lt, le;
                        lt = r_less + CNT_BITS'(r_lr < r_key);
                        le = r_leq + CNT_BITS'(r_lr <= r_key);
                        r_less <= lt; r_leq <= le;
                        r_state <= S_RD;
                        if (r_v == r_n - 1'b1) begin
                            if (lt <= r_target && r_target < le) begin
                                r_ans <= r_key;
                                r_state <= S_SQRT;
                            end else begin
                                r_j <= r_j + 1'b1;
                                r_v <= r_j + 1'b1;
                                r_found <= 1'b1;
                            end
                        end else begin
                            r_v <= r_v + 1'b1;
                        end
                    end
                end
                S_SQRT: r_state <= S_WAIT;
                S_WAIT: begin
                    if (sq_done) begin
                        o_result.payload <= '{sq: r_ans, fix: sq_root, few: r_few,
                                              dropped: r_dropped};
                        o_result.valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_result.ready) begin
                        o_result.valid <= 1'b0;
                        r_n <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign sq_start = (r_state == S_SQRT);

    slkc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_ans),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );
endmodule
`default_nettype wire
